// ===== design/kbdiff_pkg.sv =====
// ----------------------------------------------------------------------------
// kbdiff_pkg: shared types and constants of the keyboard report differ
// Word formats, op codes, and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package kbdiff_pkg;

   localparam int KEY_SLOTS_DEF  = 6;
   localparam int SCANCODE_COUNT = 256;
   localparam int INPUT_KEYS     = 6;
   localparam int MOD_COUNT      = 8;
   localparam int SCAN_W         = 8;
   localparam int CODE_W         = 10;
   localparam int MOD_SEL_W      = $clog2(MOD_COUNT);

   localparam logic [SCAN_W-1:0] MOD_BASE = 8'd224;
   localparam logic [SCAN_W-1:0] MIN_KEY  = 8'd3;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef struct packed {
      logic              op;
      logic [SCAN_W-1:0] map_index;
      logic [CODE_W-1:0] map_code;
      logic [7:0]        modifiers;
      logic [SCAN_W-1:0] key_a;
      logic [SCAN_W-1:0] key_b;
      logic [SCAN_W-1:0] key_c;
      logic [SCAN_W-1:0] key_d;
      logic [SCAN_W-1:0] key_e;
      logic [SCAN_W-1:0] key_f;
   } kbdiff_req_type;

   typedef struct packed {
      logic [SCAN_W-1:0] scan_code;
      logic [CODE_W-1:0] key_code;
      logic              pressed;
      logic              sync;
      logic              last;
   } kbdiff_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_map;
      logic start;
      logic read;
      logic advance;
      logic push_event;
      logic push_sync;
   } kbdiff_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic cand;
      logic emit_ok;
      logic step_last;
      logic out_free;
   } kbdiff_sts_type;

endpackage

// ===== design/kbdiff_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbdiff_ctrl: sequencer of the keyboard report differ
// Issues keymap loads and walks one report through its event steps: check,
// keymap fetch, emit, and the closing sync word.
// ----------------------------------------------------------------------------
module kbdiff_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_op,
   output logic                       req_ready,
   input  kbdiff_pkg::kbdiff_sts_type sts,
   output kbdiff_pkg::kbdiff_cmd_type cmd
);
   import kbdiff_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_SYNC  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  cmd.load_map = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sts.cand) begin
               cmd.read = 1'b1;
               state_in = ST_FETCH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = sts.step_last ? ST_SYNC : ST_SCAN;
            end
         end
         ST_FETCH: begin
            // drop unmapped slot keys, hold while the output is full
            if (!sts.emit_ok) begin
               cmd.advance = 1'b1;
               state_in    = sts.step_last ? ST_SYNC : ST_SCAN;
            end else if (sts.out_free) begin
               cmd.push_event = 1'b1;
               cmd.advance    = 1'b1;
               state_in       = sts.step_last ? ST_SYNC : ST_SCAN;
            end
         end
         ST_SYNC: begin
            if (sts.out_free) begin
               cmd.push_sync = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/kbdiff_dp.sv =====
// ----------------------------------------------------------------------------
// kbdiff_dp: datapath of the keyboard report differ
// Keymap memory, old and new key sets, step decode, membership test and the
// output word register.
// ----------------------------------------------------------------------------
module kbdiff_dp #(
   parameter int KEY_SLOTS = kbdiff_pkg::KEY_SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kbdiff_pkg::kbdiff_req_type req_data,
   input  kbdiff_pkg::kbdiff_cmd_type cmd,
   output kbdiff_pkg::kbdiff_sts_type sts,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output kbdiff_pkg::kbdiff_rsp_type rsp_data
);
   import kbdiff_pkg::*;

   localparam int STEP_COUNT = MOD_COUNT + 2 * KEY_SLOTS;
   localparam int STEP_W     = $clog2(STEP_COUNT);
   localparam int SLOT_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   logic [CODE_W-1:0] keymap_ff [SCANCODE_COUNT];
   logic [CODE_W-1:0] rd_code_ff;

   logic [SCAN_W-1:0] prior_ff [KEY_SLOTS];
   logic [SCAN_W-1:0] prior_in [KEY_SLOTS];
   logic [SCAN_W-1:0] fresh_ff [KEY_SLOTS];
   logic [SCAN_W-1:0] fresh_in [KEY_SLOTS];
   logic [SCAN_W-1:0] in_keys  [INPUT_KEYS];
   logic [7:0]        mods_ff;
   logic [7:0]        mods_in;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [SCAN_W-1:0] scan_ff;
   logic [SCAN_W-1:0] scan_in;
   logic              press_ff;
   logic              press_in;
   logic              is_mod_ff;
   logic              is_mod_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   kbdiff_rsp_type    rsp_data_ff;
   kbdiff_rsp_type    rsp_data_in;

   logic              is_mod;
   logic              is_press;
   logic [STEP_W-1:0] slot_step;
   logic [SLOT_W-1:0] slot;
   logic [SCAN_W-1:0] cur_scan;
   logic              held;
   logic              out_free;

   assign in_keys[0] = req_data.key_a;
   assign in_keys[1] = req_data.key_b;
   assign in_keys[2] = req_data.key_c;
   assign in_keys[3] = req_data.key_d;
   assign in_keys[4] = req_data.key_e;
   assign in_keys[5] = req_data.key_f;

   // step decode: modifiers first, then release/press pairs per slot
   always_comb begin
      is_mod    = (step_ff < STEP_W'(MOD_COUNT));
      slot_step = step_ff - STEP_W'(MOD_COUNT);
      slot      = slot_step[SLOT_W:1];
      is_press  = slot_step[0];
      if (is_mod) begin
         cur_scan = MOD_BASE + SCAN_W'(step_ff[MOD_SEL_W-1:0]);
      end else if (is_press) begin
         cur_scan = fresh_ff[slot];
      end else begin
         cur_scan = prior_ff[slot];
      end
      held = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (is_press) begin
            held = held | (prior_ff[i] == cur_scan);
         end else begin
            held = held | (fresh_ff[i] == cur_scan);
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sts.cand      = is_mod || ((cur_scan > MIN_KEY) && !held);
      sts.emit_ok   = is_mod_ff || (rd_code_ff != '0);
      sts.step_last = (step_ff == STEP_W'(STEP_COUNT - 1));
      sts.out_free  = out_free;
   end

   always_comb begin
      step_in   = step_ff;
      scan_in   = scan_ff;
      press_in  = press_ff;
      is_mod_in = is_mod_ff;
      mods_in   = mods_ff;
      fresh_in  = fresh_ff;
      prior_in  = prior_ff;
      if (cmd.start) begin
         step_in = '0;
         mods_in = req_data.modifiers;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            fresh_in[i] = (i < INPUT_KEYS) ? in_keys[i % INPUT_KEYS] : '0;
         end
      end else if (cmd.advance) begin
         step_in = step_ff + 1'b1;
      end
      if (cmd.read) begin
         scan_in   = cur_scan;
         is_mod_in = is_mod;
         press_in  = is_mod ? mods_ff[step_ff[MOD_SEL_W-1:0]] : is_press;
      end
      if (cmd.push_sync) begin
         prior_in = fresh_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.push_event) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.scan_code = scan_ff;
         rsp_data_in.key_code  = rd_code_ff;
         rsp_data_in.pressed   = press_ff;
         rsp_data_in.sync      = 1'b0;
         rsp_data_in.last      = 1'b0;
      end else if (cmd.push_sync) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in           = '0;
         rsp_data_in.sync      = 1'b1;
         rsp_data_in.last      = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // keymap: one write port for loads, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_map) begin
         keymap_ff[req_data.map_index] <= req_data.map_code;
      end
      if (cmd.read) begin
         rd_code_ff <= keymap_ff[cur_scan];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            prior_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         prior_ff     <= prior_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      press_ff    <= press_in;
      is_mod_ff   <= is_mod_in;
      mods_ff     <= mods_in;
      fresh_ff    <= fresh_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/keyboard_report_diff_events.sv =====
// ----------------------------------------------------------------------------
// keyboard_report_diff_events: boot keyboard report to key event converter
// Top level: joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
// A load word (op = 0) writes one keymap entry and gives no result; load all
// entries that reports will touch before sending reports. A report word
// (op = 1) gives eight modifier events, then per key slot a release of an
// old key missing from the new set and a press of a new key missing from
// the old set (scancodes 0 to 3 and keys mapped to zero give nothing), and
// ends with a sync word that has sync and last set. A report is accepted,
// then each modifier and each slot key that passes the membership test is
// read from the keymap and then emitted or dropped, a slot step that does
// not pass is skipped, and the sync word closes the report; emits and the
// sync word wait while the output register is full. The keymap has a single
// read port, whose registered data comes in the cycle after the address. A
// new word is taken as soon as the sync word sits in the output register.
// ----------------------------------------------------------------------------
module keyboard_report_diff_events #(
   parameter int KEY_SLOTS = kbdiff_pkg::KEY_SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  kbdiff_pkg::kbdiff_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output kbdiff_pkg::kbdiff_rsp_type rsp_data
);
   import kbdiff_pkg::*;

   kbdiff_cmd_type cmd;
   kbdiff_sts_type sts;

   // sequence the report steps; take new words only when idle
   kbdiff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold keymap, key sets and the output word
   kbdiff_dp #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
